@@ rtl/fpfa_pkg.sv @@
package fpfa_pkg;

	localparam int AMT_W  = 16;
	localparam int PIDX_W = 4;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_ALLOC = 1'b1;

	localparam logic [1:0] FIT_WORST = 2'd0;
	localparam logic [1:0] FIT_FIRST = 2'd1;
	localparam logic [1:0] FIT_BEST  = 2'd2;

	localparam logic [0:0] REG_FIT_MODE = 1'd0;
	localparam logic [0:0] REG_ACTIVE   = 1'd1;

	localparam logic [1:0] FIT_MODE_RST = FIT_FIRST;
	localparam logic [4:0] ACTIVE_RST   = 5'd16;

	typedef struct packed {
		logic              is_alloc;
		logic              load_ok;
		logic [PIDX_W-1:0] part_index;
		logic [AMT_W-1:0]  amount;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} queue_head_t;

endpackage

@@ rtl/fpfa_ram.sv @@
module fpfa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/fpfa_front.sv @@
module fpfa_front
	import fpfa_pkg::*;
#(
	parameter int PARTITIONS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic                s_tuser,
	input  logic [23:0]         s_tdata,
	input  logic                pop,
	output queue_head_t         head
);

	item_t      entries_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	item_t      item_in;
	logic       push;
	logic       do_pop;

	// Classify: decode the kind and range-check the load target.
	always_comb begin
		item_in.is_alloc   = (s_tuser == OP_ALLOC);
		item_in.part_index = s_tdata[PIDX_W-1:0];
		item_in.amount     = s_tdata[PIDX_W+AMT_W-1:PIDX_W];
		item_in.load_ok    = (s_tuser == OP_LOAD) &&
			(32'(s_tdata[PIDX_W-1:0]) < PARTITIONS);
	end

	assign s_tready = (cnt_q != 2'd2);
	assign push     = s_tvalid && s_tready;
	assign do_pop   = pop && (cnt_q != 2'd0);

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, do_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign head.valid = (cnt_q != 2'd0);
	assign head.item  = entries_q[rd_ptr_q];

endmodule

@@ rtl/fpfa_back.sv @@
module fpfa_back
	import fpfa_pkg::*;
#(
	parameter int PARTITIONS = 16,
	parameter int SIZE_BITS  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  queue_head_t head,
	output logic        pop,
	input  logic [1:0]  fit_mode,
	input  logic [4:0]  active_partitions,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic        m_tuser,
	output logic [39:0] m_tdata
);

	localparam int IDX_W = $clog2(PARTITIONS);
	localparam int CNT_W = $clog2(PARTITIONS + 1);
	localparam int LIM_W = (CNT_W > 5) ? CNT_W : 5;
	localparam int CMP_W = (SIZE_BITS > AMT_W) ? SIZE_BITS : AMT_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	state_t               state_q;
	logic [CNT_W-1:0]     k_q;
	logic                 rd_vld_s1;
	logic [IDX_W-1:0]     k_s1;
	logic [AMT_W-1:0]     req_q;
	logic                 found_q;
	logic [IDX_W-1:0]     pick_q;
	logic [CMP_W-1:0]     best_q;
	logic [SIZE_BITS-1:0] best_size_q;
	logic                 used_q [PARTITIONS];

	logic                 out_vld_q;
	logic                 out_granted_q;
	logic [PIDX_W-1:0]    out_idx_q;
	logic [AMT_W-1:0]     out_size_q;
	logic [AMT_W-1:0]     out_left_q;

	logic [LIM_W-1:0]     lim;
	logic                 issue;
	logic                 load_we;
	logic [SIZE_BITS-1:0] ram_rdata;
	logic [CMP_W-1:0]     sz_ext;
	logic [CMP_W-1:0]     left;
	logic                 hit;
	logic                 take;
	logic                 out_free;

	assign lim = (LIM_W'(active_partitions) > LIM_W'(PARTITIONS)) ?
		LIM_W'(PARTITIONS) : LIM_W'(active_partitions);

	assign pop      = (state_q == ST_IDLE) && head.valid;
	assign load_we  = pop && !head.item.is_alloc && head.item.load_ok;
	assign issue    = (state_q == ST_SCAN) && (LIM_W'(k_q) < lim) &&
		!((fit_mode != FIT_WORST) && (fit_mode != FIT_BEST) && found_q);
	assign out_free = !out_vld_q || m_tready;

	fpfa_ram #(
		.WIDTH(SIZE_BITS),
		.DEPTH(PARTITIONS)
	) u_sizes (
		.clk  (clk),
		.we   (load_we),
		.waddr(IDX_W'(head.item.part_index)),
		.wdata(SIZE_BITS'(head.item.amount)),
		.raddr(k_q[IDX_W-1:0]),
		.rdata(ram_rdata)
	);

	// Compare the partition read last cycle against the request.
	always_comb begin
		sz_ext = CMP_W'(ram_rdata);
		left   = sz_ext - CMP_W'(req_q);
		hit    = rd_vld_s1 && !used_q[k_s1] && (sz_ext >= CMP_W'(req_q));
		take   = hit && (!found_q ||
			((fit_mode == FIT_WORST) && (left > best_q)) ||
			((fit_mode == FIT_BEST) && (left < best_q)));
	end

	always_ff @(posedge clk) begin
		if (pop && head.item.is_alloc) begin
			req_q <= head.item.amount;
		end
		k_s1 <= k_q[IDX_W-1:0];
		if (take) begin
			pick_q      <= k_s1;
			best_q      <= left;
			best_size_q <= ram_rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			k_q           <= '0;
			rd_vld_s1     <= 1'b0;
			found_q       <= 1'b0;
			out_vld_q     <= 1'b0;
			out_granted_q <= 1'b0;
			out_idx_q     <= '0;
			out_size_q    <= '0;
			out_left_q    <= '0;
			for (int i = 0; i < PARTITIONS; i++) begin
				used_q[i] <= 1'b0;
			end
		end else begin
			// In the done state a drained result is replaced by the next one below.
			if (out_vld_q && m_tready && (state_q != ST_DONE)) begin
				out_vld_q <= 1'b0;
			end
			rd_vld_s1 <= issue;
			if (issue) begin
				k_q <= k_q + CNT_W'(1);
			end
			if (take) begin
				found_q <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						if (head.item.is_alloc) begin
							k_q     <= '0;
							found_q <= 1'b0;
							state_q <= ST_SCAN;
						end else if (head.item.load_ok) begin
							used_q[IDX_W'(head.item.part_index)] <= 1'b0;
						end
					end
				end
				ST_SCAN: begin
					if (!issue) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_vld_q     <= 1'b1;
						out_granted_q <= found_q;
						out_idx_q     <= found_q ? PIDX_W'(pick_q) : '0;
						out_size_q    <= found_q ? AMT_W'(best_size_q) : '0;
						out_left_q    <= found_q ? AMT_W'(best_q) : '0;
						if (found_q) begin
							used_q[pick_q] <= 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tuser  = out_granted_q;
	assign m_tdata  = {4'd0, out_left_q, out_size_q, out_idx_q};

`ifndef ASSERT_OFF
	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> $past(state_q == ST_DONE))
		else $error("result appeared outside the done state");

	a_pick_marked_used: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_free && found_q) |=> used_q[$past(pick_q)])
		else $error("granted partition not marked used");

	a_fail_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && !out_granted_q) |->
		(out_idx_q == '0 && out_size_q == '0 && out_left_q == '0))
		else $error("failed allocation carries nonzero fields");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (LIM_W'(k_q) <= lim))
		else $error("scan counter beyond partition limit");
`endif

endmodule

@@ rtl/fixed_partition_fit_allocator_core.sv @@
// Fixed partition fit allocator.
// Input stream (s_*): s_tuser is the opcode (0 load, 1 allocate). A load transfer
// writes a partition size and frees that partition; an allocate transfer carries
// a request size and yields one result transfer on the output stream (m_*).
// Output stream: m_tuser is the granted flag; m_tdata carries index, size and
// leftover of the chosen partition, all zero on a failed allocation.
// Placement policy and the number of scanned partitions come from the write
// port (cfg_*); write it only while the block is idle.
// Operation: a load is applied in the back end as it is popped from the queue.
// An allocate is popped from the queue, then each scanned partition passes a
// registered size read and goes through the single compare unit, and the result
// is posted from the done state. First fit stops early at the first match.
// A two-entry queue decouples input from the scanner, so new transfers are taken
// while a scan runs or a result waits. When the receiver stalls, the result is
// held in the output register and the scanner waits before posting the next one.
// Reset clears every used flag, sets first fit and 16 partitions. Sizes are
// undefined until loaded.
module fixed_partition_fit_allocator_core
	import fpfa_pkg::*;
#(
	parameter int PARTITIONS = 16,
	parameter int SIZE_BITS  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic        s_tuser,   // opcode
	input  logic [23:0] s_tdata,   // part_index[3:0], amount[19:4], zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic        m_tuser,   // granted
	output logic [39:0] m_tdata,   // chosen_index[3:0], chosen_size[19:4],
	                               // leftover[35:20], zero pad
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [4:0]  cfg_wdata
);

	logic [1:0]  fit_mode_q;
	logic [4:0]  active_q;
	queue_head_t head;
	logic        pop;

	// Hold the configuration registers; writes take effect at once.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_mode_q <= FIT_MODE_RST;
			active_q   <= ACTIVE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FIT_MODE: fit_mode_q <= cfg_wdata[1:0];
				REG_ACTIVE:   active_q   <= cfg_wdata;
				default:      active_q   <= active_q;
			endcase
		end
	end

	// Front: accept and classify transfers, queue them for the scanner.
	fpfa_front #(
		.PARTITIONS(PARTITIONS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tuser (s_tuser),
		.s_tdata (s_tdata),
		.pop     (pop),
		.head    (head)
	);

	// Back: apply loads, scan partitions for allocations, post results.
	fpfa_back #(
		.PARTITIONS(PARTITIONS),
		.SIZE_BITS (SIZE_BITS)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.head             (head),
		.pop              (pop),
		.fit_mode         (fit_mode_q),
		.active_partitions(active_q),
		.m_tvalid         (m_tvalid),
		.m_tready         (m_tready),
		.m_tuser          (m_tuser),
		.m_tdata          (m_tdata)
	);

endmodule
